>>> rtl/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package itp_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
    logic       overflow;
  } result_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SIN   = 8'h73;
  localparam logic [7:0] CH_CTG   = 8'h63;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_G     = 8'h67;

  // Precedence as an unsigned rank; rank 0 stands for "no operator".
  function automatic logic [2:0] prec_rank(input logic [7:0] ch);
    logic [2:0] r;
    if (ch == CH_SIN || ch == CH_CTG) r = 3'd4;
    else if (ch == CH_CARET) r = 3'd3;
    else if (ch == CH_STAR || ch == CH_SLASH) r = 3'd2;
    else if (ch == CH_PLUS || ch == CH_MINUS) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic is_function(input logic [7:0] ch);
    return (ch == CH_SIN) || (ch == CH_CTG);
  endfunction

  function automatic logic is_skipped(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_I) || (ch == CH_N) || (ch == CH_T) ||
           (ch == CH_G);
  endfunction

  function automatic logic is_copied(input logic [7:0] ch);
    logic alnum;
    alnum = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7A) ||
            (ch >= 8'h41 && ch <= 8'h5A);
    return (ch == CH_DOT) || (alnum && !is_function(ch));
  endfunction

endpackage
`default_nettype wire

>>> rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// Infix to postfix converter with an operator stack in a synchronous memory.
// The item channel takes one infix character, or an end mark that drains the
// stack, per transaction; the result channel gives postfix characters, and
// the final character caused by an item carries last.
// Items are handled one at a time: item_stall stays high from acceptance
// until the item's last result has been loaded into the output register.
// A skipped character gives no result; a copied character goes through S_COPY
// and an open bracket through S_PUSH, then S_FLUSH. An operator, a close
// bracket or an end mark reads stack entries through S_RD and S_TOP, gives
// the results of each pop in S_POP and ends in S_FLUSH; an operator that is
// pushed first passes S_SPACE (not for sin or ctg) and S_PUSH. A pop gives
// a space and the operator, then i and n for sin or t and g for ctg.
// A push onto a full stack gives one result with overflow set.
// Reset empties the stack and clears both channels; stack entries are not
// cleared, since only written entries are ever read.
// When the receiver stalls, the output register and one pending character
// hold, and the sequencer waits until the output register is taken.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  wire itp_pkg::item_t item,
  output logic                result_valid,
  input  wire                 result_stall,
  output itp_pkg::result_t    result
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_TOP   = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_SPACE = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;
  localparam logic [2:0] S_COPY  = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [7:0]    op_stack [STACK_DEPTH];
  logic [7:0]    rdata;
  logic          rd_en;
  logic          wr_en;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    pop_idx;
  logic [1:0]    pop_idx_next;
  logic          kind;
  logic [7:0]    ch;

  logic          pend_valid;
  logic [7:0]    pend_char;
  logic          pend_ovf;
  logic          emit;
  logic [7:0]    emit_char;
  logic          emit_ovf;
  logic          out_free;
  logic          can_emit;
  logic          flush;
  logic [CW-1:0] top_addr;
  logic [1:0]    pop_final;
  logic          accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign can_emit   = !pend_valid || out_free;
  assign top_addr   = count - CW'(1);
  assign pop_final  = itp_pkg::is_function(rdata) ? 2'd3 : 2'd1;

  always_comb begin
    state_next   = state;
    count_next   = count;
    pop_idx_next = pop_idx;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    emit         = 1'b0;
    emit_char    = itp_pkg::CH_SPACE;
    emit_ovf     = 1'b0;
    flush        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.kind == itp_pkg::KIND_END) state_next = S_RD;
          else if (itp_pkg::is_skipped(item.char_in)) state_next = S_IDLE;
          else if (itp_pkg::is_copied(item.char_in)) state_next = S_COPY;
          else if (item.char_in == itp_pkg::CH_OPEN) state_next = S_PUSH;
          else state_next = S_RD;
        end
      end
      S_RD: begin
        if (count == '0) begin
          if (kind == itp_pkg::KIND_END || ch == itp_pkg::CH_CLOSE) state_next = S_FLUSH;
          else if (itp_pkg::is_function(ch)) state_next = S_PUSH;
          else state_next = S_SPACE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        pop_idx_next = 2'd0;
        if (kind == itp_pkg::KIND_END) begin
          state_next = S_POP;
        end else if (ch == itp_pkg::CH_CLOSE) begin
          if (rdata == itp_pkg::CH_OPEN) begin
            count_next = count - CW'(1);
            state_next = S_FLUSH;
          end else begin
            state_next = S_POP;
          end
        end else if (itp_pkg::prec_rank(ch) <= itp_pkg::prec_rank(rdata)) begin
          state_next = S_POP;
        end else if (itp_pkg::is_function(ch)) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_SPACE;
        end
      end
      S_POP: begin
        unique case (pop_idx)
          2'd0: emit_char = itp_pkg::CH_SPACE;
          2'd1: emit_char = rdata;
          2'd2: emit_char = (rdata == itp_pkg::CH_SIN) ? itp_pkg::CH_I : itp_pkg::CH_T;
          default: emit_char = (rdata == itp_pkg::CH_SIN) ? itp_pkg::CH_N : itp_pkg::CH_G;
        endcase
        if (can_emit) begin
          emit = 1'b1;
          if (pop_idx == pop_final) begin
            count_next = count - CW'(1);
            state_next = S_RD;
          end else begin
            pop_idx_next = pop_idx + 2'd1;
          end
        end
      end
      S_SPACE: begin
        emit_char = itp_pkg::CH_SPACE;
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        emit_char = ch;
        emit_ovf  = 1'b1;
        if (count >= FULL) begin
          if (can_emit) begin
            emit       = 1'b1;
            state_next = S_FLUSH;
          end
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          state_next = S_FLUSH;
        end
      end
      S_COPY: begin
        emit_char = ch;
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_FLUSH;
        end
      end
      default: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          flush      = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) op_stack[count[AW-1:0]] <= ch;
    if (rd_en) rdata <= op_stack[top_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= item.kind;
      ch   <= item.char_in;
    end
    if (emit) begin
      pend_char <= emit_char;
      pend_ovf  <= emit_ovf;
    end
    if ((emit && pend_valid) || flush) begin
      result.char_out <= pend_char;
      result.overflow <= pend_ovf;
      result.last     <= flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pop_idx      <= 2'd0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pop_idx <= pop_idx_next;
      if (emit) pend_valid <= 1'b1;
      else if (flush) pend_valid <= 1'b0;
      if ((emit && pend_valid) || flush) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> tb/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps
module infix_to_postfix_converter_tb;

  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 35;

  typedef struct {
    itp_pkg::item_t it;
    bit             typed;
    string          want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  itp_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  itp_pkg::result_t result;

  logic [7:0]       opstack [DEPTH];
  int               opstack_len = 0;
  itp_pkg::result_t step_chars[$];
  itp_pkg::result_t postfix_expected[$];
  itp_pkg::result_t head;
  int               errors = 0;
  int               items_sent = 0;
  int               cycles = 0;
  int               send_idle_pct = 38;
  int               recv_stall_pct = 59;

  dir_row_t dir_rows[29] = '{
    '{'{itp_pkg::KIND_CHAR, "a"}, 1'b1, "a"},
    '{'{itp_pkg::KIND_CHAR, "Z"}, 1'b1, "Z"},
    '{'{itp_pkg::KIND_CHAR, "."}, 1'b1, "."},
    '{'{itp_pkg::KIND_CHAR, " "}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "g"}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, ")"}, 1'b1, ""},
    '{'{itp_pkg::KIND_END, 8'h00}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "s"}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, "x"}, 1'b1, "x"},
    '{'{itp_pkg::KIND_CHAR, "^"}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, "^"}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, "c"}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, ")"}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, "/"}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, 8'hFF}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, 8'h00}, 1'b0, ""},
    '{'{itp_pkg::KIND_END, 8'hFF}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b1, ""},
    '{'{itp_pkg::KIND_CHAR, "("}, 1'b0, ""},
    '{'{itp_pkg::KIND_CHAR, "-"}, 1'b0, ""},
    '{'{itp_pkg::KIND_END, 8'h00}, 1'b0, ""}
  };

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #2 clk = ~clk;

  function automatic int priority_of(input logic [7:0] ch);
    if (ch == itp_pkg::CH_SIN || ch == itp_pkg::CH_CTG) return 4;
    if (ch == itp_pkg::CH_CARET) return 3;
    if (ch == itp_pkg::CH_STAR || ch == itp_pkg::CH_SLASH) return 2;
    if (ch == itp_pkg::CH_PLUS || ch == itp_pkg::CH_MINUS) return 1;
    return -1;
  endfunction

  function automatic void emit_char(input logic [7:0] ch, input logic ovf);
    itp_pkg::result_t r;
    r.char_out = ch;
    r.last = 1'b0;
    r.overflow = ovf;
    step_chars = {step_chars, r};
  endfunction

  function automatic void pop_operator();
    logic [7:0] op;
    op = opstack[opstack_len - 1];
    emit_char(itp_pkg::CH_SPACE, 1'b0);
    emit_char(op, 1'b0);
    if (op == itp_pkg::CH_SIN) begin
      emit_char(itp_pkg::CH_I, 1'b0);
      emit_char(itp_pkg::CH_N, 1'b0);
    end else if (op == itp_pkg::CH_CTG) begin
      emit_char(itp_pkg::CH_T, 1'b0);
      emit_char(itp_pkg::CH_G, 1'b0);
    end
    opstack_len--;
  endfunction

  function automatic void push_operator(input logic [7:0] ch);
    if (opstack_len >= DEPTH) begin
      emit_char(ch, 1'b1);
    end else begin
      opstack[opstack_len] = ch;
      opstack_len++;
    end
  endfunction

  // Works out the postfix characters one transaction on the item side causes.
  function automatic void convert_item(input itp_pkg::item_t it);
    logic [7:0] ch;
    bit         alnum;
    int         p;
    ch = it.char_in;
    alnum = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7A) ||
            (ch >= 8'h41 && ch <= 8'h5A);
    if (it.kind == itp_pkg::KIND_END) begin
      while (opstack_len > 0) pop_operator();
    end else if (ch == itp_pkg::CH_SPACE || ch == itp_pkg::CH_I || ch == itp_pkg::CH_N ||
                 ch == itp_pkg::CH_T || ch == itp_pkg::CH_G) begin
    end else if (ch == itp_pkg::CH_DOT ||
                 (alnum && ch != itp_pkg::CH_SIN && ch != itp_pkg::CH_CTG)) begin
      emit_char(ch, 1'b0);
    end else if (ch == itp_pkg::CH_OPEN) begin
      push_operator(ch);
    end else if (ch == itp_pkg::CH_CLOSE) begin
      while (opstack_len > 0 && opstack[opstack_len - 1] != itp_pkg::CH_OPEN) pop_operator();
      if (opstack_len > 0) opstack_len--;
    end else begin
      p = priority_of(ch);
      while (opstack_len > 0 && p <= priority_of(opstack[opstack_len - 1])) pop_operator();
      if (ch != itp_pkg::CH_SIN && ch != itp_pkg::CH_CTG) emit_char(itp_pkg::CH_SPACE, 1'b0);
      push_operator(ch);
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(input itp_pkg::item_t it, input bit typed = 1'b0,
                           input string want = "");
    itp_pkg::result_t r;
    int               k;
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
    step_chars.delete();
    convert_item(it);
    if (typed) begin
      for (k = 0; k < want.len(); k++) begin
        r.char_out = want[k];
        r.last = (k == want.len() - 1);
        r.overflow = 1'b0;
        postfix_expected = {postfix_expected, r};
      end
    end else begin
      foreach (step_chars[j]) postfix_expected = {postfix_expected, step_chars[j]};
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    itp_pkg::item_t it;
    it.kind = itp_pkg::KIND_CHAR;
    it.char_in = ch;
    send_item(it);
  endtask

  task automatic send_noise();
    itp_pkg::item_t it;
    it.kind = ($urandom_range(7) == 0) ? itp_pkg::KIND_END : itp_pkg::KIND_CHAR;
    it.char_in = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic send_expression();
    itp_pkg::item_t it;
    logic [7:0]     ch;
    int             len;
    len = $urandom_range(2, 14);
    repeat (len) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          case ($urandom_range(3))
            0: ch = 8'(8'h30 + $urandom_range(9));
            1: ch = 8'(8'h41 + $urandom_range(25));
            2: ch = 8'(8'h61 + $urandom_range(25));
            default: ch = itp_pkg::CH_DOT;
          endcase
          send_char(ch);
        end
        3, 4: begin
          case ($urandom_range(4))
            0: ch = itp_pkg::CH_PLUS;
            1: ch = itp_pkg::CH_MINUS;
            2: ch = itp_pkg::CH_STAR;
            3: ch = itp_pkg::CH_SLASH;
            default: ch = itp_pkg::CH_CARET;
          endcase
          send_char(ch);
        end
        5: begin
          if ($urandom_range(1)) begin
            send_char(itp_pkg::CH_SIN);
            send_char(itp_pkg::CH_I);
            send_char(itp_pkg::CH_N);
          end else begin
            send_char(itp_pkg::CH_CTG);
            send_char(itp_pkg::CH_T);
            send_char(itp_pkg::CH_G);
          end
        end
        6: send_char(itp_pkg::CH_OPEN);
        7: send_char(itp_pkg::CH_CLOSE);
        8: send_char(itp_pkg::CH_SPACE);
        default: repeat ($urandom_range(2, 9)) send_char(itp_pkg::CH_OPEN);
      endcase
    end
    it.kind = itp_pkg::KIND_END;
    it.char_in = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic report_mismatch(input string field, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, field, want_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // A transaction on the result side completes at the next rising edge.
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (postfix_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, got char_out 'h%0h last %0b overflow %0b",
                 $time, result.char_out, result.last, result.overflow);
        errors++;
      end else begin
        head = postfix_expected.pop_front();
        if (result.char_out !== head.char_out)
          report_mismatch("char_out", head.char_out, result.char_out);
        if (result.last !== head.last) report_mismatch("last", head.last, result.last);
        if (result.overflow !== head.overflow)
          report_mismatch("overflow", head.overflow, result.overflow);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[r]) send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_stall_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_expression();
      end
    end
    item_valid <= 1'b0;
    while (postfix_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("infix_to_postfix_converter_tb: PASS");
    end else begin
      $display("infix_to_postfix_converter_tb: FAIL");
    end
    $finish;
  end

endmodule
